// File: rtl/lstb_pkg.sv
// Shared types, register indexes and the divide-by-255 helper for the subpixel text blend.
`timescale 1ns / 1ps
package lstb_pkg;

	localparam int ChanW = 8;
	localparam int ProdW = 2 * ChanW;
	localparam int CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] REG_TEXT_RED   = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_TEXT_GREEN = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_TEXT_BLUE  = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_BGR_ORDER  = 2'd3;

	typedef struct packed {
		logic [ChanW-1:0] r;
		logic [ChanW-1:0] g;
		logic [ChanW-1:0] b;
	} rgb_t;

	typedef struct packed {
		logic [ChanW-1:0] a;
		logic [ChanW-1:0] r;
		logic [ChanW-1:0] g;
		logic [ChanW-1:0] b;
	} pix_t;

	typedef struct packed {
		rgb_t col;
		rgb_t cov;
		pix_t dest;
		logic touched;
	} scl_t;

	// Exact floor(x / 255) for any x up to 255 * 255.
	function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] x);
		logic [ProdW:0] t;
		t = {1'b0, x} + {{ProdW{1'b0}}, 1'b1} + {{(ChanW+1){1'b0}}, x[ProdW-1:ChanW]};
		return t[ProdW-1:ChanW];
	endfunction

endpackage

// File: rtl/lstb_scale.sv
// Two pipeline stages that scale the text color and coverages by the shadow alpha.
`timescale 1ns / 1ps
module lstb_scale import lstb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  rgb_t             col,
	input  rgb_t             cov,
	input  pix_t             dest,
	input  logic [ChanW-1:0] shadow_alpha,
	output logic             out_valid,
	output scl_t             out_item
);

	logic             valid_s1;
	logic [ProdW-1:0] col_r_s1, col_g_s1, col_b_s1;
	logic [ProdW-1:0] cov_r_s1, cov_g_s1, cov_b_s1;
	pix_t             dest_s1;
	logic             valid_s2;
	scl_t             item_s2;
	rgb_t             col_sc;
	rgb_t             cov_sc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// A shadow alpha of 255 scales every value to itself, so no bypass is needed.
	always_ff @(posedge clk) begin
		col_r_s1 <= col.r * shadow_alpha;
		col_g_s1 <= col.g * shadow_alpha;
		col_b_s1 <= col.b * shadow_alpha;
		cov_r_s1 <= cov.r * shadow_alpha;
		cov_g_s1 <= cov.g * shadow_alpha;
		cov_b_s1 <= cov.b * shadow_alpha;
		dest_s1  <= dest;
	end

	always_comb begin
		col_sc.r = div255(col_r_s1);
		col_sc.g = div255(col_g_s1);
		col_sc.b = div255(col_b_s1);
		cov_sc.r = div255(cov_r_s1);
		cov_sc.g = div255(cov_g_s1);
		cov_sc.b = div255(cov_b_s1);
	end

	always_ff @(posedge clk) begin
		item_s2.col     <= col_sc;
		item_s2.cov     <= cov_sc;
		item_s2.dest    <= dest_s1;
		item_s2.touched <= (cov_sc.r != '0) || (cov_sc.g != '0) || (cov_sc.b != '0);
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

endmodule

// File: rtl/lstb_blend.sv
// Two pipeline stages that blend one color channel toward the text color by its coverage.
`timescale 1ns / 1ps
module lstb_blend import lstb_pkg::*; (
	input  logic             clk,
	input  logic [ChanW-1:0] dest,
	input  logic [ChanW-1:0] col,
	input  logic [ChanW-1:0] cov,
	output logic [ChanW-1:0] res
);

	logic signed [ChanW:0]    diff;
	logic signed [ProdW+1:0]  prod_s3;
	logic [ChanW-1:0]         dest_s3;
	logic [ProdW+1:0]         mag;
	logic [ChanW-1:0]         quot;
	logic [ChanW-1:0]         step;
	logic [ChanW-1:0]         res_s4;

	assign diff = $signed({1'b0, col}) - $signed({1'b0, dest});

	always_ff @(posedge clk) begin
		prod_s3 <= (ProdW+2)'(diff * $signed({1'b0, cov}));
		dest_s3 <= dest;
	end

	// The quotient truncates toward zero, so divide the magnitude and restore the sign.
	always_comb begin
		mag  = prod_s3[ProdW+1] ? (ProdW+2)'(-prod_s3) : prod_s3;
		quot = div255(mag[ProdW-1:0]);
		step = prod_s3[ProdW+1] ? (~quot + 8'd1) : quot;
	end

	always_ff @(posedge clk) begin
		res_s4 <= dest_s3 + step;
	end

	assign res = res_s4;

endmodule

// File: rtl/lcd_subpixel_text_blend.sv
// Top level of the subpixel text blend: configuration registers, pipeline and result strobe.
//
//  Channel   Handshake               Payload
//  -------   ---------------------   ------------------------------------------------
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data
//  command   start / busy            cov_first..cov_third, dest_*, shadow_alpha
//  result    done (strobe)           out_blue, out_green, out_red, out_alpha
//
// One pixel enters per cycle; busy never rises. Each accepted transaction moves through the
// scale stages s1, s2 and the blend stages s3, s4 and is then on the result ports, marked by
// done. There are four register stages: two for shadow scaling, two for the channel blend.
// Reset clears the color registers, the channel order and the valid bits of the pipeline.
// The receiver takes every result as it comes, so the pipeline never stalls.
`timescale 1ns / 1ps
module lcd_subpixel_text_blend import lstb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [ChanW-1:0]   cfg_data,
	input  logic               start,
	output logic               busy,
	input  logic [ChanW-1:0]   cov_first,
	input  logic [ChanW-1:0]   cov_second,
	input  logic [ChanW-1:0]   cov_third,
	input  logic [ChanW-1:0]   dest_blue,
	input  logic [ChanW-1:0]   dest_green,
	input  logic [ChanW-1:0]   dest_red,
	input  logic [ChanW-1:0]   dest_alpha,
	input  logic [ChanW-1:0]   shadow_alpha,
	output logic               done,
	output logic [ChanW-1:0]   out_blue,
	output logic [ChanW-1:0]   out_green,
	output logic [ChanW-1:0]   out_red,
	output logic [ChanW-1:0]   out_alpha
);

	logic [ChanW-1:0] text_red_q, text_green_q, text_blue_q;
	logic             bgr_order_q;
	logic             accept;
	rgb_t             col_in;
	rgb_t             cov_in;
	pix_t             dest_in;
	logic             valid_s2;
	scl_t             item_s2;
	logic             valid_s3, valid_s4;
	logic             touched_s3, touched_s4;
	logic [ChanW-1:0] alpha_s3, alpha_s4;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_red_q   <= '0;
			text_green_q <= '0;
			text_blue_q  <= '0;
			bgr_order_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TEXT_RED: begin
					text_red_q <= cfg_data;
				end
				REG_TEXT_GREEN: begin
					text_green_q <= cfg_data;
				end
				REG_TEXT_BLUE: begin
					text_blue_q <= cfg_data;
				end
				REG_BGR_ORDER: begin
					bgr_order_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		col_in.r   = text_red_q;
		col_in.g   = text_green_q;
		col_in.b   = text_blue_q;
		cov_in.r   = bgr_order_q ? cov_third : cov_first;
		cov_in.g   = cov_second;
		cov_in.b   = bgr_order_q ? cov_first : cov_third;
		dest_in.a  = dest_alpha;
		dest_in.r  = dest_red;
		dest_in.g  = dest_green;
		dest_in.b  = dest_blue;
	end

	lstb_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (accept),
		.col          (col_in),
		.cov          (cov_in),
		.dest         (dest_in),
		.shadow_alpha (shadow_alpha),
		.out_valid    (valid_s2),
		.out_item     (item_s2)
	);

	lstb_blend u_blend_red (
		.clk  (clk),
		.dest (item_s2.dest.r),
		.col  (item_s2.col.r),
		.cov  (item_s2.cov.r),
		.res  (out_red)
	);

	lstb_blend u_blend_green (
		.clk  (clk),
		.dest (item_s2.dest.g),
		.col  (item_s2.col.g),
		.cov  (item_s2.cov.g),
		.res  (out_green)
	);

	lstb_blend u_blend_blue (
		.clk  (clk),
		.dest (item_s2.dest.b),
		.col  (item_s2.col.b),
		.cov  (item_s2.cov.b),
		.res  (out_blue)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		touched_s3 <= item_s2.touched;
		alpha_s3   <= item_s2.dest.a;
		touched_s4 <= touched_s3;
		alpha_s4   <= touched_s3 ? '0 : alpha_s3;
	end

	assign done      = valid_s4;
	assign out_alpha = alpha_s4;

	// A result strobe appears only after a valid item has passed the blend stage s3.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s3))
		else $error("result strobe without an item in the blend stage");

	// With zero shadow alpha the destination pixel passes through unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start && shadow_alpha == 8'd0, 4)) |->
		(out_red == $past(dest_red, 4) && out_green == $past(dest_green, 4) &&
		 out_blue == $past(dest_blue, 4) && out_alpha == $past(dest_alpha, 4)))
		else $error("zero shadow alpha changed the destination pixel");

	// Full green coverage of solid text yields exactly the text green and clears the alpha.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start && shadow_alpha == 8'd255 && cov_second == 8'd255, 4)) |->
		(out_green == $past(text_green_q, 4) && out_alpha == 8'd0))
		else $error("full coverage did not produce the text color");

	// An untouched pixel keeps its alpha, a touched one clears it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !touched_s4) |-> (out_alpha == $past(alpha_s3)))
		else $error("untouched pixel lost its destination alpha");

endmodule

// File: tb/sv/lstb_blend_checker.sv
// Checker for the subpixel text blend: tracks register writes, predicts each pixel and compares.
`timescale 1ns / 1ps
module lstb_blend_checker import lstb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [ChanW-1:0]   cfg_data,
	input  logic               start,
	input  logic               busy,
	input  logic [ChanW-1:0]   cov_first,
	input  logic [ChanW-1:0]   cov_second,
	input  logic [ChanW-1:0]   cov_third,
	input  logic [ChanW-1:0]   dest_blue,
	input  logic [ChanW-1:0]   dest_green,
	input  logic [ChanW-1:0]   dest_red,
	input  logic [ChanW-1:0]   dest_alpha,
	input  logic [ChanW-1:0]   shadow_alpha,
	input  logic               done,
	input  logic [ChanW-1:0]   out_blue,
	input  logic [ChanW-1:0]   out_green,
	input  logic [ChanW-1:0]   out_red,
	input  logic [ChanW-1:0]   out_alpha,
	output int                 mismatches,
	output int                 pending
);

	typedef struct packed {
		logic [ChanW-1:0] blue;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] red;
		logic [ChanW-1:0] alpha;
	} blended_t;

	localparam logic [ChanW-1:0] Opaque = 8'hFF;

	logic [ChanW-1:0] color_red;
	logic [ChanW-1:0] color_green;
	logic [ChanW-1:0] color_blue;
	logic             swap_rb;
	blended_t         expected_pixels[$];
	blended_t         want;

	function automatic int scale_by_alpha(input int x, input int a);
		return (x * a) / 255;
	endfunction

	// Signed division truncates toward zero, so the channel stays between dest and color.
	function automatic logic [ChanW-1:0] mix_channel(input int dest, input int color, input int cov);
		int delta;
		delta = ((color - dest) * cov) / 255;
		return ChanW'(dest + delta);
	endfunction

	function automatic blended_t blend_pixel(input logic [ChanW-1:0] c1, c2, c3,
			input logic [ChanW-1:0] db, dg, dr, da, sa);
		int col_r, col_g, col_b, cov_r, cov_g, cov_b;
		blended_t px;
		col_r = color_red;
		col_g = color_green;
		col_b = color_blue;
		cov_g = c2;
		if (swap_rb) begin
			cov_r = c3;
			cov_b = c1;
		end else begin
			cov_r = c1;
			cov_b = c3;
		end
		if (sa != Opaque) begin
			col_r = scale_by_alpha(col_r, sa);
			col_g = scale_by_alpha(col_g, sa);
			col_b = scale_by_alpha(col_b, sa);
			cov_r = scale_by_alpha(cov_r, sa);
			cov_g = scale_by_alpha(cov_g, sa);
			cov_b = scale_by_alpha(cov_b, sa);
		end
		px.blue = mix_channel(db, col_b, cov_b);
		px.green = mix_channel(dg, col_g, cov_g);
		px.red = mix_channel(dr, col_r, cov_r);
		px.alpha = (cov_r == 0 && cov_g == 0 && cov_b == 0) ? da : 8'd0;
		return px;
	endfunction

	task automatic report_error(input string msg);
		$display("%0t ERROR: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string field, input logic [ChanW-1:0] got, want_val);
		if (got !== want_val)
			report_error($sformatf("%s is %0d, expected %0d", field, got, want_val));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_red = '0;
			color_green = '0;
			color_blue = '0;
			swap_rb = 1'b0;
			expected_pixels.delete();
			pending = 0;
		end else begin
			if (done) begin
				if (expected_pixels.size() == 0) begin
					report_error("result transaction with no pixel outstanding");
				end else begin
					want = expected_pixels.pop_front();
					check_field("out_blue", out_blue, want.blue);
					check_field("out_green", out_green, want.green);
					check_field("out_red", out_red, want.red);
					check_field("out_alpha", out_alpha, want.alpha);
				end
			end
			if (start && !busy)
				expected_pixels.insert(expected_pixels.size(),
					blend_pixel(cov_first, cov_second, cov_third,
					dest_blue, dest_green, dest_red, dest_alpha, shadow_alpha));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TEXT_RED: color_red = cfg_data;
					REG_TEXT_GREEN: color_green = cfg_data;
					REG_TEXT_BLUE: color_blue = cfg_data;
					REG_BGR_ORDER: swap_rb = cfg_data[0];
					default: ;
				endcase
			end
			pending = expected_pixels.size();
		end
	end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top for the subpixel text blend: clock, reset, register setup, pixel stimulus, verdict.
`timescale 1ns / 1ps
module tb_top import lstb_pkg::*;;

	localparam int NumPhases = 8;
	localparam int PixelsPerPhase = 225;
	localparam int Latency = 8;
	localparam int CycleLimit = 200000;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [ChanW-1:0]   cfg_data;
	logic               start;
	logic               busy;
	logic [ChanW-1:0]   cov_first;
	logic [ChanW-1:0]   cov_second;
	logic [ChanW-1:0]   cov_third;
	logic [ChanW-1:0]   dest_blue;
	logic [ChanW-1:0]   dest_green;
	logic [ChanW-1:0]   dest_red;
	logic [ChanW-1:0]   dest_alpha;
	logic [ChanW-1:0]   shadow_alpha;
	logic               done;
	logic [ChanW-1:0]   out_blue;
	logic [ChanW-1:0]   out_green;
	logic [ChanW-1:0]   out_red;
	logic [ChanW-1:0]   out_alpha;
	int                 mismatches;
	int                 pending;
	int                 cycle_count;

	lcd_subpixel_text_blend dut (.*);
	lstb_blend_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic idle_gap(input int percent);
		while ($urandom_range(99) < percent) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_pixel(input logic [ChanW-1:0] c1, c2, c3, db, dg, dr, da, sa);
		cov_first <= c1;
		cov_second <= c2;
		cov_third <= c3;
		dest_blue <= db;
		dest_green <= dg;
		dest_red <= dr;
		dest_alpha <= da;
		shadow_alpha <= sa;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	// Lets the pipeline empty so that the registers can be changed safely.
	task automatic drain;
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (Latency) @(posedge clk);
	endtask

	task automatic configure(input logic [ChanW-1:0] red, green, blue, input logic bgr);
		logic [CfgIdxW-1:0] idx[4];
		logic [ChanW-1:0] val[4];
		idx = '{REG_TEXT_RED, REG_TEXT_GREEN, REG_TEXT_BLUE, REG_BGR_ORDER};
		val = '{red, green, blue, {7'd0, bgr}};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [ChanW-1:0] rand_cov();
		case ($urandom_range(3))
			0: return 8'd0;
			1: return 8'd255;
			default: return ChanW'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [ChanW-1:0] rand_shadow();
		case ($urandom_range(9))
			0, 1, 2, 3: return 8'd255;
			4: return 8'd0;
			5: return 8'd1;
			6: return 8'd254;
			default: return ChanW'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [ChanW-1:0] rand_dest();
		if ($urandom_range(7) == 0)
			return $urandom_range(1) ? 8'd255 : 8'd0;
		return ChanW'($urandom_range(255));
	endfunction

	task automatic directed_pixels;
		send_pixel(8'd0, 8'd0, 8'd0, 8'd10, 8'd20, 8'd30, 8'd40, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd0, 8'd128, 8'd128, 8'd128, 8'd9, 8'd255);
		send_pixel(8'd0, 8'd0, 8'd255, 8'd77, 8'd66, 8'd55, 8'd44, 8'd255);
		send_pixel(8'd200, 8'd100, 8'd50, 8'd1, 8'd2, 8'd3, 8'd4, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255, 8'd200, 8'd100, 8'd50, 8'd99, 8'd1);
		send_pixel(8'd1, 8'd1, 8'd1, 8'd255, 8'd255, 8'd255, 8'd123, 8'd254);
		send_pixel(8'd1, 8'd2, 8'd3, 8'd250, 8'd5, 8'd130, 8'd7, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128, 8'd255, 8'd0, 8'd170, 8'd1, 8'd128);
		send_pixel(8'd0, 8'd255, 8'd0, 8'd85, 8'd85, 8'd85, 8'd0, 8'd200);
		send_pixel(8'd170, 8'd85, 8'd15, 8'd240, 8'd15, 8'd90, 8'd170, 8'd127);
	endtask

	initial begin
		int idle_pct;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		start <= 1'b0;
		cov_first <= '0;
		cov_second <= '0;
		cov_third <= '0;
		dest_blue <= '0;
		dest_green <= '0;
		dest_red <= '0;
		dest_alpha <= '0;
		shadow_alpha <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < NumPhases; p++) begin
			if (p > 0)
				drain();
			case (p)
				0: ;
				1: configure(8'd255, 8'd255, 8'd255, 1'b1);
				2: configure(8'd0, 8'd0, 8'd0, 1'b1);
				3: configure(8'd255, 8'd0, 8'd255, 1'b0);
				4: configure(8'd1, 8'd254, 8'd128, 1'b1);
				default: configure(ChanW'($urandom_range(255)), ChanW'($urandom_range(255)),
					ChanW'($urandom_range(255)), 1'($urandom_range(1)));
			endcase
			if (p < 2)
				directed_pixels();
			case (p % 3)
				0: idle_pct = 0;
				1: idle_pct = 88;
				default: idle_pct = 15;
			endcase
			for (int n = 0; n < PixelsPerPhase; n++) begin
				idle_gap(idle_pct);
				send_pixel(rand_cov(), rand_cov(), rand_cov(), rand_dest(), rand_dest(),
					rand_dest(), rand_dest(), rand_shadow());
			end
		end
		drain();
		if (mismatches == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
